>>> rtl/fault_event_supervisor_top_defines.svh
// ----------------------------------------------------------------------------
// fault event supervisor assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FAULT_EVENT_SUPERVISOR_TOP_DEFINES_SVH
`define FAULT_EVENT_SUPERVISOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define FES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fault event supervisor: property violated");

// next-cycle implication, disabled while reset is asserted
`define FES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fault event supervisor: property violated");

`endif

>>> rtl/fes_pkg.sv
// ----------------------------------------------------------------------------
// fes_pkg
// types and constants of the fault event supervisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fes_pkg;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT      = 3'd0,
    CFG_ACTION_SEL   = 3'd1,
    CFG_ACTIVE_HOLD  = 3'd2,
    CFG_THR_CONTINUE = 3'd3,
    CFG_GCS_CONTINUE = 3'd4,
    CFG_THR_CODE     = 3'd5,
    CFG_GCS_CODE     = 3'd6
  } cfg_idx_e;

  // configured failsafe action
  typedef enum logic [2:0] {
    SEL_NONE        = 3'd0,
    SEL_SMART       = 3'd1,
    SEL_RETURN      = 3'd2,
    SEL_HOLD        = 3'd3,
    SEL_SMART_HOLD  = 3'd4,
    SEL_LOITER_HOLD = 3'd5,
    SEL_TERMINATE   = 3'd6
  } action_sel_e;

  // action actually taken
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_CONTINUE = 3'd1,
    ACT_SMART    = 3'd2,
    ACT_RETURN   = 3'd3,
    ACT_HOLD     = 3'd4,
    ACT_LOITER   = 3'd5,
    ACT_DISARM   = 3'd6
  } action_e;

  // vehicle modes
  typedef enum logic [1:0] {
    MODE_OTHER   = 2'd0,
    MODE_MISSION = 2'd1,
    MODE_RETURN  = 2'd2,
    MODE_PAUSED  = 2'd3
  } mode_e;

  // configuration reset values
  localparam logic [19:0] TIMEOUT_RST    = 20'd1500;
  localparam logic [2:0]  ACTION_SEL_RST = SEL_SMART_HOLD;
  localparam logic [7:0]  THR_CODE_RST   = 8'd1;
  localparam logic [7:0]  GCS_CODE_RST   = 8'd4;

  typedef struct packed {
    logic [19:0] timeout_ms;
    logic [2:0]  action_select;
    logic        active_in_hold;
    logic        throttle_continue;
    logic        gcs_continue;
    logic [7:0]  throttle_event_code;
    logic [7:0]  gcs_event_code;
  } fes_cfg_t;

  typedef struct packed {
    logic [7:0]  event_mask;
    logic        turn_on;
    logic [31:0] now_ms;
    logic [1:0]  vehicle_mode;
    logic        smart_return_ok;
    logic        return_ok;
    logic        loiter_ok;
  } fes_req_t;

  typedef struct packed {
    logic [7:0] active_bits;
    logic [7:0] latched_bits;
    logic       episode_started;
    logic       episode_cleared;
    logic       gcs_flag_valid;
    logic       gcs_flag;
    logic       fired;
    logic [2:0] action_taken;
  } fes_rsp_t;

  typedef struct packed {
    logic [7:0]  fault_bits;
    logic [7:0]  triggered_bits;
    logic [31:0] episode_start_ms;
  } fes_state_t;

endpackage

>>> rtl/fes_if.sv
// ----------------------------------------------------------------------------
// fes_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// request channel
interface fes_in_if;
  logic             valid;
  logic             ready;
  fes_pkg::fes_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// result channel
interface fes_out_if;
  logic             valid;
  logic             ready;
  fes_pkg::fes_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/fault_event_supervisor_top.sv
// ----------------------------------------------------------------------------
// fault_event_supervisor_top: fault episode timing and failsafe action
// request register, then result register; one request per cycle while results are taken
// fault state is updated combinationally between the two registers, once per evaluated request
// async active-low reset clears fault state and loads register defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fault_event_supervisor_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fes_in_if.sink                         in_i,
  fes_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [fes_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fes_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import fes_pkg::*;

  fes_cfg_t   cfg;
  fes_state_t state_q, state_d;
  fes_req_t   req_q;
  fes_rsp_t   rsp_d, rsp_q;
  logic       req_valid_q;
  logic       rsp_valid_q;
  logic       out_free;
  logic       advance;

  // configuration bank
  fes_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // evaluation of the registered request
  fes_eval u_eval (
    .cfg_i   (cfg),
    .state_i (state_q),
    .req_i   (req_q),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  // handshake: result register frees when taken, request moves when it can
  assign out_free   = !rsp_valid_q || out_o.ready;
  assign advance    = req_valid_q && out_free;
  assign in_i.ready = !req_valid_q || out_free;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      req_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_q <= in_i.payload;
    end
  end

  // supervisor state, updated once per evaluated request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (out_free) begin
      rsp_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_o.valid   = rsp_valid_q;
  assign out_o.payload = rsp_q;

endmodule

>>> rtl/fes_cfg.sv
// ----------------------------------------------------------------------------
// fes_cfg
// configuration register bank with plain write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fes_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fes_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fes_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output fes_pkg::fes_cfg_t                 cfg_o
);
  import fes_pkg::*;

  fes_cfg_t cfg_q, cfg_d;

  // register write decode, unknown indexes ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMEOUT:      cfg_d.timeout_ms          = cfg_wdata_i[19:0];
        CFG_ACTION_SEL:   cfg_d.action_select       = cfg_wdata_i[2:0];
        CFG_ACTIVE_HOLD:  cfg_d.active_in_hold      = cfg_wdata_i[0];
        CFG_THR_CONTINUE: cfg_d.throttle_continue   = cfg_wdata_i[0];
        CFG_GCS_CONTINUE: cfg_d.gcs_continue        = cfg_wdata_i[0];
        CFG_THR_CODE:     cfg_d.throttle_event_code = cfg_wdata_i[7:0];
        CFG_GCS_CODE:     cfg_d.gcs_event_code      = cfg_wdata_i[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  // register bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ms          <= TIMEOUT_RST;
      cfg_q.action_select       <= ACTION_SEL_RST;
      cfg_q.active_in_hold      <= 1'b0;
      cfg_q.throttle_continue   <= 1'b0;
      cfg_q.gcs_continue        <= 1'b0;
      cfg_q.throttle_event_code <= THR_CODE_RST;
      cfg_q.gcs_event_code      <= GCS_CODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/fes_eval.sv
// ----------------------------------------------------------------------------
// fes_eval
// one-pass evaluation of a request against the supervisor state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fes_eval (
  input  fes_pkg::fes_cfg_t   cfg_i,
  input  fes_pkg::fes_state_t state_i,
  input  fes_pkg::fes_req_t   req_i,
  output fes_pkg::fes_state_t state_o,
  output fes_pkg::fes_rsp_t   rsp_o
);
  import fes_pkg::*;

  logic [7:0]  bits_new;
  logic [7:0]  trig_kept;
  logic [31:0] start_new;
  logic [31:0] elapsed;
  logic        started;
  logic        cleared;
  logic        gcs_match;
  logic        thr_match;
  logic        timed_out;
  logic        mode_allows;
  logic        fire;
  logic        keep_auto;
  action_e     resolved;
  action_e     action;

  // set or clear the fault bits, track episode start
  always_comb begin
    bits_new  = req_i.turn_on ? (state_i.fault_bits | req_i.event_mask)
                              : (state_i.fault_bits & ~req_i.event_mask);
    started   = (state_i.fault_bits == 8'd0) && (bits_new != 8'd0);
    start_new = started ? req_i.now_ms : state_i.episode_start_ms;
    cleared   = (state_i.triggered_bits != 8'd0) && (bits_new == 8'd0);
    trig_kept = state_i.triggered_bits & bits_new;
  end

  // source matches and wrapping timeout compare
  always_comb begin
    gcs_match   = (req_i.event_mask == cfg_i.gcs_event_code);
    thr_match   = (req_i.event_mask == cfg_i.throttle_event_code);
    elapsed     = req_i.now_ms - start_new;
    timed_out   = elapsed > {12'd0, cfg_i.timeout_ms};
    mode_allows = (req_i.vehicle_mode != MODE_RETURN) &&
                  ((req_i.vehicle_mode != MODE_PAUSED) || cfg_i.active_in_hold);
    fire        = (trig_kept == 8'd0) && (bits_new != 8'd0) && timed_out && mode_allows;
    keep_auto   = (req_i.vehicle_mode == MODE_MISSION) &&
                  ((thr_match && cfg_i.throttle_continue) ||
                   (gcs_match && cfg_i.gcs_continue));
  end

  // configured action with fallbacks
  always_comb begin
    case (cfg_i.action_select)
      SEL_NONE:        resolved = ACT_NONE;
      SEL_SMART:       resolved = req_i.smart_return_ok ? ACT_SMART :
                                  (req_i.return_ok ? ACT_RETURN : ACT_HOLD);
      SEL_RETURN:      resolved = req_i.return_ok ? ACT_RETURN : ACT_HOLD;
      SEL_HOLD:        resolved = ACT_HOLD;
      SEL_SMART_HOLD:  resolved = req_i.smart_return_ok ? ACT_SMART : ACT_HOLD;
      SEL_LOITER_HOLD: resolved = req_i.loiter_ok ? ACT_LOITER : ACT_HOLD;
      SEL_TERMINATE:   resolved = ACT_DISARM;
      default:         resolved = ACT_NONE;
    endcase
  end

  // final action
  always_comb begin
    if (!fire) begin
      action = ACT_NONE;
    end else if (keep_auto) begin
      action = ACT_CONTINUE;
    end else begin
      action = resolved;
    end
  end

  // next state and result
  always_comb begin
    state_o.fault_bits       = bits_new;
    state_o.triggered_bits   = fire ? bits_new : trig_kept;
    state_o.episode_start_ms = start_new;

    rsp_o.active_bits     = bits_new;
    rsp_o.latched_bits    = state_o.triggered_bits;
    rsp_o.episode_started = started;
    rsp_o.episode_cleared = cleared;
    rsp_o.gcs_flag_valid  = gcs_match;
    rsp_o.gcs_flag        = gcs_match & req_i.turn_on;
    rsp_o.fired           = fire;
    rsp_o.action_taken    = action;
  end

endmodule

>>> rtl/fes_checker.sv
// ----------------------------------------------------------------------------
// fes_checker
// port-level properties of the fault event supervisor, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fault_event_supervisor_top_defines.svh"

module fes_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input fes_pkg::fes_rsp_t out_rsp_i
);
  import fes_pkg::*;

  // a stalled result stays put
  `FES_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_rsp_i))

  // an action only comes with a firing
  `FES_ASSERT_IMP(a_action_needs_fire, clk_i, rst_ni, out_valid_i && !out_rsp_i.fired, out_rsp_i.action_taken == ACT_NONE)

  // a firing latches exactly the active, nonzero bits
  `FES_ASSERT_IMP(a_fire_latches, clk_i, rst_ni, out_valid_i && out_rsp_i.fired, (out_rsp_i.latched_bits == out_rsp_i.active_bits) && (out_rsp_i.active_bits != 8'd0))

  // latched bits never outlive their active bits
  `FES_ASSERT_IMP(a_latched_subset, clk_i, rst_ni, out_valid_i, (out_rsp_i.latched_bits & ~out_rsp_i.active_bits) == 8'd0)

  // a cleared episode leaves nothing active
  `FES_ASSERT_IMP(a_clear_empty, clk_i, rst_ni, out_valid_i && out_rsp_i.episode_cleared, (out_rsp_i.active_bits == 8'd0) && !out_rsp_i.fired)

endmodule

bind fault_event_supervisor_top fes_checker u_fes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_rsp_i   (out_o.payload)
);
